### sv/linear_ramp_envelope_defines.svh
// Assertion macros shared by the checker of the linear ramp envelope.
// No dependencies; expects clk and rst_n in the scope of each use.
`ifndef LINEAR_RAMP_ENVELOPE_DEFINES_SVH
`define LINEAR_RAMP_ENVELOPE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define LRE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/lre_pkg.sv
// Shared types and constants of the linear ramp envelope.
// No dependencies; used by every module of the block except lre_ram.
package lre_pkg;

    localparam int CHANNELS_DEF = 8;

    localparam int CHAN_W    = 3;
    localparam int LEVEL_W   = 24;
    localparam int TIME_W    = 32;
    localparam int RATE_W    = 19;
    localparam int ACC_W     = 40;
    localparam int LEN_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = RATE_W + TIME_W;
    localparam int LRAW_W    = PROD_W - FRAC_W;
    localparam int DIV_W     = ACC_W + 1;
    localparam int DIV_STEPS = DIV_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam int S_TDATA_W = 88;
    localparam int S_TUSER_W = CHAN_W;
    localparam int M_TDATA_W = LEVEL_W;
    localparam int M_TUSER_W = CHAN_W + 1;

    localparam logic [RATE_W-1:0] SAMPLE_RATE_RESET = 19'd48000;

    localparam logic [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
    localparam logic [DIV_W-1:0] Q_POS_LIM = {2'b00, {(ACC_W-1){1'b1}}};
    localparam logic [DIV_W-1:0] Q_NEG_LIM = {2'b01, {(ACC_W-1){1'b0}}};

    typedef struct packed {
        logic [ACC_W-1:0] acc;
        logic [ACC_W-1:0] inc;
        logic [LEN_W-1:0] step;
        logic [LEN_W-1:0] len;
    } env_state_t;

    localparam int STATE_W = $bits(env_state_t);

    typedef struct packed {
        logic accept;
        logic mul;
        logic len;
        logic div_step;
        logic sat;
        logic finish;
    } lre_cmd_t;

    typedef struct packed {
        logic in_range;
        logic need_restart;
        logic short_ramp;
        logic div_last;
        logic out_free;
    } lre_status_t;

endpackage

### sv/linear_ramp_envelope.sv
// Top level of the per-channel linear ramp envelope generator.
// Depends on lre_pkg, lre_ctrl, lre_datapath and lre_ram.
//
// Usage:
//   s_axis carries one sample beat: tuser is the channel, tdata holds the
//   start and end levels (Q4.20), ramp time (Q16.16), trigger and loop bits.
//   m_axis returns one beat per input beat: tdata is the level (Q4.20)
//   before this sample's increment, tuser the channel and a finished flag.
//   cfg_we/cfg_wdata write the sample rate in hertz; write only while idle.
//   One beat is processed at a time. An in-range beat that restarts a ramp
//   of at least one step (trigger, or loop at ramp end) runs the 41-step
//   restoring divider for the increment before write-back; any other beat,
//   a short-ramp restart included, skips the divider. The result is
//   registered at write-back, and the next beat is accepted after that.
//   The output register lets the next beat be accepted while a result is
//   still held; when the receiver stalls, the following result waits in
//   the write-back step and holds tready low.
//   Reset sets the sample rate to 48000 and clears every channel's state
//   at once through per-channel valid bits; no clearing pass is needed.
module linear_ramp_envelope #(
    parameter int CHANNELS = lre_pkg::CHANNELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lre_pkg::RATE_W-1:0]    cfg_wdata,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // start_level[23:0], end_level[47:24], ramp_time[79:48],
    // trigger[80], loop_enable[81], zero[87:82]
    input  logic [lre_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // channel[2:0]
    input  logic [lre_pkg::S_TUSER_W-1:0] s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // level[23:0]
    output logic [lre_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // channel_out[2:0], finished[3]
    output logic [lre_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    lre_pkg::lre_cmd_t    cmd;
    lre_pkg::lre_status_t sts;

    lre_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .cmd           (cmd),
        .sts           (sts)
    );

    lre_datapath #(
        .CHANNELS (CHANNELS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

### sv/lre_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lre_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### sv/lre_ctrl.sv
// Sequencer of the linear ramp envelope: steps one beat through read,
// multiply, divide (restarts only) and write-back. Depends on lre_pkg.
module lre_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    output lre_pkg::lre_cmd_t    cmd,
    input  lre_pkg::lre_status_t sts
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_LEN,
        ST_DIV,
        ST_SAT,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid && ready_reg)
                begin
                    cmd.accept = 1'b1;
                    ready_next = 1'b0;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                cmd.len = 1'b1;
                if (sts.in_range && sts.need_restart && !sts.short_ramp)
                begin
                    state_next = ST_DIV;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_SAT;
                end
            end
            ST_SAT:
            begin
                cmd.sat    = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    ready_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_axis_tready = ready_reg;

endmodule

### sv/lre_datapath.sv
// Datapath of the linear ramp envelope: input latch, length multiplier,
// restoring divider, channel state RAM and output register.
// Depends on lre_pkg and lre_ram.
module lre_datapath #(
    parameter int CHANNELS = lre_pkg::CHANNELS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  lre_pkg::lre_cmd_t                cmd,
    output lre_pkg::lre_status_t             sts,
    input  logic                             cfg_we,
    input  logic [lre_pkg::RATE_W-1:0]       cfg_wdata,
    input  logic [lre_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    input  logic [lre_pkg::S_TUSER_W-1:0]    s_axis_tuser,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lre_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    output logic [lre_pkg::M_TUSER_W-1:0]    m_axis_tuser
);

    localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    localparam int ACC_W  = lre_pkg::ACC_W;
    localparam int LEN_W  = lre_pkg::LEN_W;
    localparam int LVL_W  = lre_pkg::LEVEL_W;
    localparam int FRAC_W = lre_pkg::FRAC_W;
    localparam int DIV_W  = lre_pkg::DIV_W;
    localparam int LRAW_W = lre_pkg::LRAW_W;

    // configuration and control
    logic [lre_pkg::RATE_W-1:0] rate_reg;
    logic                       out_valid_reg;
    logic [CHANNELS-1:0]        valid_reg;

    // latched beat
    logic [lre_pkg::CHAN_W-1:0] chan_reg;
    logic [IDX_W-1:0]           idx_reg;
    logic [LVL_W-1:0]           start_reg;
    logic [LVL_W-1:0]           end_reg;
    logic [lre_pkg::TIME_W-1:0] time_reg;
    logic                       trig_reg;
    logic                       loop_reg;
    logic                       in_range_reg;
    logic                       hit_reg;

    // restart arithmetic
    logic [lre_pkg::PROD_W-1:0] prod_reg;
    logic [LEN_W-1:0]           len_reg;
    logic                       short_reg;
    logic [DIV_W-1:0]           num_reg;
    logic [LEN_W-1:0]           rem_reg;
    logic                       neg_reg;
    logic [lre_pkg::CNT_W-1:0]  cnt_reg;
    logic [ACC_W-1:0]           inc_reg;

    // output register
    logic [LVL_W-1:0]           out_level_reg;
    logic [lre_pkg::CHAN_W-1:0] out_chan_reg;
    logic                       out_fin_reg;

    logic [IDX_W-1:0]           in_idx;
    logic                       in_range_next;
    logic [lre_pkg::STATE_W-1:0] rdata;
    logic                       ram_we;

    lre_pkg::env_state_t st;
    lre_pkg::env_state_t rs;
    lre_pkg::env_state_t cur;
    lre_pkg::env_state_t st_next;

    logic [LRAW_W-1:0]  len_raw;
    logic [LRAW_W-1:0]  len_m1;
    logic [LEN_W-1:0]   len_next;
    logic               short_next;
    logic [LVL_W:0]     diff;
    logic [LVL_W:0]     mag;
    logic [LEN_W:0]     rem_sh;
    logic [LEN_W+1:0]   trial;
    logic [ACC_W-1:0]   inc_next;
    logic [ACC_W:0]     sum;
    logic [ACC_W-1:0]   sum_sat;
    logic               adv;
    logic               fin_next;

    assign in_idx        = IDX_W'(s_axis_tuser);
    assign in_range_next = (32'(s_axis_tuser) < 32'(CHANNELS));

    lre_ram #(
        .WIDTH (lre_pkg::STATE_W),
        .DEPTH (CHANNELS)
    ) u_state_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (st_next),
        .re    (cmd.accept),
        .raddr (in_idx),
        .rdata (rdata)
    );

    always_comb
    begin
        st = hit_reg ? lre_pkg::env_state_t'(rdata) : '0;

        // restart values
        rs.step = '0;
        if (short_reg)
        begin
            rs.acc = {end_reg, {FRAC_W{1'b0}}};
            rs.inc = '0;
            rs.len = '0;
        end
        else
        begin
            rs.acc = {start_reg, {FRAC_W{1'b0}}};
            rs.inc = inc_reg;
            rs.len = len_reg;
        end

        cur = trig_reg ? rs : st;
        adv = (cur.step < cur.len);

        sum = {cur.acc[ACC_W-1], cur.acc} + {cur.inc[ACC_W-1], cur.inc};
        if (sum[ACC_W] != sum[ACC_W-1])
        begin
            sum_sat = sum[ACC_W] ? lre_pkg::ACC_MIN : lre_pkg::ACC_MAX;
        end
        else
        begin
            sum_sat = sum[ACC_W-1:0];
        end

        st_next  = cur;
        fin_next = 1'b0;
        if (adv)
        begin
            st_next.acc  = sum_sat;
            st_next.step = cur.step + LEN_W'(1);
        end
        else if (loop_reg)
        begin
            st_next = rs;
        end
        else
        begin
            fin_next = 1'b1;
        end
    end

    // ramp length from the registered product
    always_comb
    begin
        len_raw    = prod_reg[lre_pkg::PROD_W-1:FRAC_W];
        short_next = (len_raw <= LRAW_W'(1));
        len_m1     = len_raw - LRAW_W'(1);
        len_next   = (|len_m1[LRAW_W-1:LEN_W]) ? {LEN_W{1'b1}} : len_m1[LEN_W-1:0];
        diff       = {end_reg[LVL_W-1], end_reg} - {start_reg[LVL_W-1], start_reg};
        mag        = diff[LVL_W] ? (~diff + (LVL_W+1)'(1)) : diff;
    end

    // one restoring division step
    always_comb
    begin
        rem_sh = {rem_reg, num_reg[DIV_W-1]};
        trial  = {1'b0, rem_sh} - {2'b00, len_reg};
    end

    // signed, saturated increment from the quotient magnitude
    always_comb
    begin
        if (neg_reg)
        begin
            inc_next = (num_reg > lre_pkg::Q_NEG_LIM) ? lre_pkg::ACC_MIN
                                                      : ACC_W'(~num_reg + DIV_W'(1));
        end
        else
        begin
            inc_next = (num_reg > lre_pkg::Q_POS_LIM) ? lre_pkg::ACC_MAX
                                                      : num_reg[ACC_W-1:0];
        end
    end

    assign ram_we = cmd.finish && in_range_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= lre_pkg::SAMPLE_RATE_RESET;
            out_valid_reg <= 1'b0;
            valid_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                rate_reg <= cfg_wdata;
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (ram_we)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            chan_reg     <= s_axis_tuser;
            idx_reg      <= in_idx;
            start_reg    <= s_axis_tdata[23:0];
            end_reg      <= s_axis_tdata[47:24];
            time_reg     <= s_axis_tdata[79:48];
            trig_reg     <= s_axis_tdata[80];
            loop_reg     <= s_axis_tdata[81];
            in_range_reg <= in_range_next;
            hit_reg      <= in_range_next ? valid_reg[in_idx] : 1'b0;
        end
        if (cmd.mul)
        begin
            prod_reg <= rate_reg * time_reg;
        end
        if (cmd.len)
        begin
            len_reg   <= len_next;
            short_reg <= short_next;
            num_reg   <= {mag, {FRAC_W{1'b0}}};
            neg_reg   <= diff[LVL_W];
            rem_reg   <= '0;
            cnt_reg   <= '0;
        end
        if (cmd.div_step)
        begin
            if (!trial[LEN_W+1])
            begin
                rem_reg <= trial[LEN_W-1:0];
                num_reg <= {num_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[LEN_W-1:0];
                num_reg <= {num_reg[DIV_W-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + lre_pkg::CNT_W'(1);
        end
        if (cmd.sat)
        begin
            inc_reg <= inc_next;
        end
        if (cmd.finish)
        begin
            out_chan_reg  <= chan_reg;
            out_level_reg <= in_range_reg ? cur.acc[ACC_W-1:FRAC_W] : '0;
            out_fin_reg   <= in_range_reg ? fin_next : 1'b1;
        end
    end

    always_comb
    begin
        sts.in_range     = in_range_reg;
        sts.need_restart = trig_reg || (loop_reg && !(st.step < st.len));
        sts.short_ramp   = short_next;
        sts.div_last     = (cnt_reg == lre_pkg::CNT_W'(lre_pkg::DIV_STEPS - 1));
        sts.out_free     = !out_valid_reg || m_axis_tready;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_level_reg;
    assign m_axis_tuser  = {out_fin_reg, out_chan_reg};

endmodule

### sv/lre_checker.sv
// Port-level checks of the linear ramp envelope, bound to the top level.
// Depends on lre_pkg and linear_ramp_envelope_defines.svh.
`include "linear_ramp_envelope_defines.svh"

module lre_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [lre_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [lre_pkg::M_TUSER_W-1:0] m_axis_tuser
);

    `LRE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "output beat dropped while stalled")
    `LRE_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata) && $stable(m_axis_tuser), "output beat changed while stalled")
    `LRE_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second beat taken before the first finished")
    `LRE_ASSERT_NEXT(a_no_early_result, s_axis_tvalid && s_axis_tready, !$rose(m_axis_tvalid), "result shown the cycle after acceptance")

endmodule

bind linear_ramp_envelope lre_checker u_lre_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
